@@ rtl/core/sos_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sos_pkg;

    localparam int SS_BITS  = 16;
    localparam int CFG_W    = 17;
    localparam int CFG_IDXW = 2;

    localparam logic [15:0] GAIN_MAX   = 16'd32768;
    localparam logic [15:0] GAIN_RESET = 16'd16384;

    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        RM_OVERDUB    = 2'd0,
        RM_NEW_SPLICE = 2'd1,
        RM_INPUT_ONLY = 2'd2
    } t_rec_mode;

    typedef enum logic [CFG_IDXW-1:0] {
        CFG_RECORD_MODE = 2'd0,
        CFG_MIX_GAIN    = 2'd1,
        CFG_LOOP_BEGIN  = 2'd2,
        CFG_SPLICE_END  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_sos_in;

    typedef struct packed {
        logic               wrote;
        logic [15:0]        write_address;
        logic signed [15:0] stored_left;
        logic signed [15:0] stored_right;
        logic [16:0]        reel_length;
        logic               rec_active;
        logic               first_splice_present;
        logic [16:0]        new_splice_begin;
    } t_sos_out;

    typedef struct packed {
        logic              busy;
        logic [SS_BITS-1:0] value;
    } t_ssm_status;

    typedef struct packed {
        logic [1:0] count;
    } t_oq_status;

endpackage

`default_nettype wire

@@ rtl/core/sos_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sos_ssmod.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sos_ssmod import sos_pkg::*; #(
    parameter int CAPACITY = 65536
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [SS_BITS-1:0] i_value,
    output t_ssm_status             o_status
);

    localparam int                 LW      = $clog2(CAPACITY);
    localparam int                 SH      = SS_BITS + LW;
    localparam longint unsigned    RECIP_L = ((64'd1 << SH) + 64'(CAPACITY) - 64'd1)
                                             / 64'(CAPACITY);
    localparam logic [17:0]        RECIP   = 18'(RECIP_L);
    localparam logic [SS_BITS-1:0] CAP_LO  = SS_BITS'(CAPACITY);
    localparam logic [24:0]        CAP_K   = 25'(CAPACITY);

    logic               r_busy, n_busy;
    logic [SS_BITS-1:0] r_x, n_x;
    logic [SS_BITS-1:0] r_q, n_q;
    logic [SS_BITS-1:0] r_rem, n_rem;
    logic [33:0]        prod;
    logic [SS_BITS-1:0] quot;

    // reciprocal multiply for the quotient, then subtract quotient times capacity
    always_comb begin
        prod   = 34'(i_value) * 34'(RECIP);
        quot   = SS_BITS'(prod >> SH);
        n_busy = i_start;
        n_x    = r_x;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_start) begin
            n_x = i_value;
            n_q = quot;
        end else if (r_busy) begin
            n_rem = r_x - SS_BITS'(r_q * CAP_LO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_x    <= '0;
            r_q    <= '0;
            r_rem  <= '0;
        end else begin
            r_busy <= n_busy;
            r_x    <= n_x;
            r_q    <= n_q;
            r_rem  <= n_rem;
        end
    end

    assign o_status.busy  = r_busy;
    assign o_status.value = r_rem;

`ifndef SYNTH
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (25'(r_rem) < CAP_K))
        else $error("splice start not reduced below capacity");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sos_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sos_outq import sos_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_sos_out i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_sos_out      o_data,
    output t_oq_status    o_status
);

    t_sos_out   r_slot [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_valid = r_cnt != 2'd0;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_slot[r_rp];
    assign o_status.count = r_cnt;

    always_comb begin
        n_wp  = i_push ? !r_wp : r_wp;
        n_rp  = pop ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < 2'd2))
        else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sound_on_sound_loop_recorder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Stereo sound-on-sound loop recorder. Each input word is a start, a stop or a
// stereo frame and yields exactly one result word. For a frame, the stereo
// store (one synchronous RAM, one read and one write port) is read in the
// accept cycle and written back with the crossfade in the next, and no new
// word is taken while that write is outstanding. A two-word result queue lets
// input continue while a result waits; the queue holds input off when both
// entries are held. After reset all CAPACITY store entries (65536 by default)
// are cleared to zero, during which no input word is taken. A write of the
// loop start register holds input off while the value is reduced modulo
// CAPACITY.
module sound_on_sound_loop_recorder import sos_pkg::*; #(
    parameter int CAPACITY = 65536
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_sos_in             i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_sos_out                 o_out,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_IDXW-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int HW = $clog2(CAPACITY + 1);
    localparam int EW = (HW > 17) ? HW : 17;

    // configuration
    logic [1:0]  r_record_mode;
    logic [15:0] r_mix_gain;
    logic [15:0] r_loop_begin;
    logic [16:0] r_splice_end;

    // recorder state
    logic [HW-1:0] r_head, n_head;
    logic [HW-1:0] r_length, n_length;
    logic [HW-1:0] r_latched, n_latched;
    logic          r_recording, n_recording;

    // store clearing after reset
    logic          r_clearing, n_clearing;
    logic [AW-1:0] r_clr_addr, n_clr_addr;

    // write-back stage
    logic               r_b_vld;
    logic               r_b_wr;
    logic [AW-1:0]      r_b_addr;
    logic signed [15:0] r_b_in_l;
    logic signed [15:0] r_b_in_r;

    t_ssm_status ssm;
    t_oq_status  oq;
    logic        cfg_acc;
    logic        in_acc;
    logic        frame_wr;

    logic [HW-1:0] h_full;
    logic [AW-1:0] h0;
    logic [EW-1:0] ss_ext;
    logic [AW-1:0] ss_a;
    logic          loop_back;
    logic [AW-1:0] addr_a;
    logic [HW-1:0] addr_next;

    logic               st_we;
    logic [AW-1:0]      st_waddr;
    logic [31:0]        st_wdata;
    logic [31:0]        rdata;
    logic signed [15:0] old_l, old_r;
    logic signed [15:0] val_l, val_r;
    logic [EW-1:0]      addr_ext, len_ext, lat_ext;
    t_sos_out           result;

    function automatic logic signed [15:0] fade(
        input logic signed [15:0] in_s,
        input logic signed [15:0] old_s,
        input logic [15:0]        g
    );
        logic signed [16:0] d;
        logic signed [33:0] prod;
        logic signed [18:0] q;
        logic signed [18:0] s;
        d    = 17'(in_s) - 17'(old_s);
        prod = 34'(d) * 34'($signed({1'b0, g}));
        q    = prod[33:15];
        s    = 19'(old_s) + q;
        return s[15:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = !r_clearing && !ssm.busy && !r_b_vld && (oq.count < 2'd2);
    assign in_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_mode <= RM_OVERDUB;
            r_mix_gain    <= GAIN_RESET;
            r_loop_begin  <= '0;
            r_splice_end  <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_RECORD_MODE: begin
                    r_record_mode <= i_cfg_data[1:0];
                end
                CFG_MIX_GAIN: begin
                    r_mix_gain <= (i_cfg_data[15:0] > GAIN_MAX) ? GAIN_MAX
                                                                : i_cfg_data[15:0];
                end
                CFG_LOOP_BEGIN: begin
                    r_loop_begin <= i_cfg_data[15:0];
                end
                CFG_SPLICE_END: begin
                    r_splice_end <= i_cfg_data[16:0];
                end
                default: begin
                end
            endcase
        end
    end

    sos_ssmod #(
        .CAPACITY(CAPACITY)
    ) u_ssmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cfg_acc && (i_cfg_index == CFG_LOOP_BEGIN)),
        .i_value  (i_cfg_data[15:0]),
        .o_status (ssm)
    );

    // frame address: wrap at capacity, then in overdub mode loop within the splice
    always_comb begin
        h_full    = (r_head == HW'(CAPACITY)) ? '0 : r_head;
        h0        = h_full[AW-1:0];
        ss_ext    = EW'(ssm.value);
        ss_a      = ss_ext[AW-1:0];
        loop_back = (r_record_mode == RM_OVERDUB)
                    && ({1'b0, r_loop_begin} < r_splice_end)
                    && (EW'(h0) >= EW'(r_splice_end));
        addr_a    = loop_back ? ss_a : h0;
        addr_next = HW'(addr_a) + HW'(1);
    end

    assign frame_wr = in_acc && (i_in.mode == KIND_FRAME) && r_recording;

    always_comb begin
        n_head      = r_head;
        n_length    = r_length;
        n_latched   = r_latched;
        n_recording = r_recording;
        if (in_acc) begin
            unique case (i_in.mode)
                KIND_START: begin
                    n_recording = 1'b1;
                    if (r_record_mode == RM_NEW_SPLICE || r_record_mode == RM_INPUT_ONLY) begin
                        n_latched = r_length;
                        n_head    = r_length;
                    end else begin
                        n_head = HW'(ssm.value);
                    end
                end
                KIND_STOP: begin
                    n_recording = 1'b0;
                end
                KIND_FRAME: begin
                    if (r_recording) begin
                        n_head = addr_next;
                        if (addr_next > r_length) begin
                            n_length = addr_next;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(CAPACITY - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_length    <= '0;
            r_latched   <= '0;
            r_recording <= 1'b0;
            r_b_vld     <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            r_head      <= n_head;
            r_length    <= n_length;
            r_latched   <= n_latched;
            r_recording <= n_recording;
            r_b_vld     <= in_acc;
            r_clearing  <= n_clearing;
            r_clr_addr  <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_wr   <= frame_wr;
            r_b_addr <= addr_a;
            r_b_in_l <= i_in.left_sample;
            r_b_in_r <= i_in.right_sample;
        end
    end

    assign st_we    = r_clearing || (r_b_vld && r_b_wr);
    assign st_waddr = r_clearing ? r_clr_addr : r_b_addr;
    assign st_wdata = r_clearing ? 32'd0 : {val_l, val_r};

    sos_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (frame_wr),
        .i_raddr (addr_a),
        .o_rdata (rdata)
    );

    // crossfade or plain input, and result
    always_comb begin
        old_l = rdata[31:16];
        old_r = rdata[15:0];
        if (r_record_mode == RM_INPUT_ONLY) begin
            val_l = r_b_in_l;
            val_r = r_b_in_r;
        end else begin
            val_l = fade(r_b_in_l, old_l, r_mix_gain);
            val_r = fade(r_b_in_r, old_r, r_mix_gain);
        end
        addr_ext = EW'(r_b_addr);
        len_ext  = EW'(r_length);
        lat_ext  = EW'(r_latched);

        result.wrote                = r_b_wr;
        result.write_address        = r_b_wr ? addr_ext[15:0] : 16'd0;
        result.stored_left          = r_b_wr ? val_l : 16'sd0;
        result.stored_right         = r_b_wr ? val_r : 16'sd0;
        result.reel_length          = len_ext[16:0];
        result.rec_active           = r_recording;
        result.first_splice_present = r_length != '0;
        result.new_splice_begin     = lat_ext[16:0];
    end

    sos_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_b_vld),
        .i_data   (result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out),
        .o_status (oq)
    );

`ifndef SYNTH
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= HW'(CAPACITY))
        else $error("record head beyond capacity");

    a_write_in_reel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && r_b_wr) |-> (HW'(r_b_addr) < r_length))
        else $error("store write outside reel length");

    a_write_recording: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && r_b_wr) |-> r_recording)
        else $error("store write while not recording");
`endif

endmodule

`default_nettype wire
